/* rtl/kli_pkg.sv */
// kli_pkg: types and constants shared by the keyframe interpolator
// no dependencies
`default_nettype none
package kli_pkg;
  localparam int NUM_CH = 9;
  localparam int VW = 32;

  // configuration register indexes
  localparam logic [0:0] REG_START_X = 1'b0;
  localparam logic [0:0] REG_START_Z = 1'b1;

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_START  = 2'd2,
    CMD_TICK   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_POSE  = 2'd0,
    ST_FIN   = 2'd1,
    ST_DONE  = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  // controller -> datapath commands
  typedef struct packed {
    logic clear;       // zero clock and count
    logic append;      // write input frame at count
    logic start_ld;    // issue read of time 0
    logic start_wr;    // load clock from read data
    logic tick_add;    // clock += dt
    logic scan_rd;     // issue time read at scan index
    logic scan_step;   // compare read data, advance
    logic seg_rd;      // read time at scan index - 1
    logic seg_ld;      // set up divider from clock and segment times
    logic div_step;    // one quotient bit
    logic ch_rd;       // read one channel word, swap prev/next
    logic ch_mul;      // multiply stage
    logic ch_acc;      // sum and store pose
    logic out_load;    // move result to output register
    status_t st;       // status for out_load
  } kli_cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic full;
    logic few;          // count < 2
    logic scan_hit;     // clock < t[idx]
    logic scan_end;     // idx reached count
    logic div_done;
    logic ch_last;
  } kli_sts_t;

  function automatic logic [VW-1:0] sat_add(input logic signed [VW:0] s);
    logic [VW-1:0] r;
    if (s > 33'sh0_7FFF_FFFF) r = 32'h7FFF_FFFF;
    else if (s < -33'sh0_8000_0000) r = 32'h8000_0000;
    else r = s[VW-1:0];
    return r;
  endfunction
endpackage
`default_nettype wire

/* rtl/keyframe_linear_interpolator.sv */
// keyframe_linear_interpolator: top level, stream ports and config registers
// depends on kli_pkg, kli_ctrl, kli_datapath
//
// usage: each input item carries a command (clear, append frame, start clock,
// tick) and gives exactly one result item with a status and nine pose values.
// appends go to a keyframe table of MAX_FRAMES rows; x is offset by start_x
// and z stored as start_z minus z, both saturating. a tick advances the clock
// by dt, scans stored times for the first one later than the clock and blends
// that frame with the previous one by a Q16 fraction.
// a tick scans the stored frames one by one over the single time memory
// port, runs the bit-serial fraction divider and then blends each channel
// in turn; the scan loop and the divider set its length. one item is in
// work at a time; in_tready is low while it runs.
// the result waits in an output register; a stalled receiver holds it and
// the next item may be accepted meanwhile, finishing into the register once
// it is free.
// reset (synchronous, rst_n low) clears clock, frame count, registers and
// output valid and holds in_tready low; table contents are undefined until
// written.
`default_nettype none
module keyframe_linear_interpolator #(
  parameter int MAX_FRAMES = 128
) (
  input  wire          clk,
  input  wire          rst_n,
  input  wire          cfg_we,
  input  wire [0:0]    cfg_index,
  input  wire [31:0]   cfg_data,
  input  wire          in_tvalid,
  output logic         in_tready,
  // cmd[1:0], dt[32:2], frame_time[64:33], x, z, y, yaw, pitch, ls, rs, lh,
  // rh in 32-bit steps up to bit 352, zero pad to 360
  input  wire [359:0]  in_tdata,
  output logic         out_tvalid,
  input  wire          out_tready,
  // status[1:0], pose_x, pose_y, pose_z, yaw, pitch, ls, rs, lh, rh, pad to 296
  output logic [295:0] out_tdata
);
  localparam int AW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;

  logic [31:0] start_x_r, start_z_r;
  logic        out_valid_r;
  logic        busy, out_set, in_fire;
  kli_pkg::kli_cmd_t cmd;
  kli_pkg::kli_sts_t sts;
  logic [1:0]      o_status;
  logic [9*32-1:0] o_pose;    // storage order x,z,y,...

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_x_r <= '0;
      start_z_r <= '0;
    end else if (cfg_we) begin
      if (cfg_index == kli_pkg::REG_START_X) start_x_r <= cfg_data;
      else start_z_r <= cfg_data;
    end
  end

  assign in_tready = !busy && rst_n;
  assign in_fire = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (out_set) out_valid_r <= 1'b1;
    else if (out_tready) out_valid_r <= 1'b0;
  end
  assign out_tvalid = out_valid_r;

  kli_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .in_cmd(in_tdata[1:0]),
    .out_free(!out_valid_r || out_tready), .busy(busy), .out_set(out_set),
    .cmd(cmd), .sts(sts)
  );

  kli_datapath #(.MAX_FRAMES(MAX_FRAMES), .AW(AW)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .start_x(start_x_r), .start_z(start_z_r),
    .dt(in_tdata[32:2]), .f_time(in_tdata[64:33]), .f_ch(in_tdata[352:65]),
    .o_status(o_status), .o_pose(o_pose)
  );

  // output order is x, y, z, then the rest as stored
  assign out_tdata = {6'd0, o_pose[287:96], o_pose[63:32], o_pose[95:64],
                      o_pose[31:0], o_status};
endmodule
`default_nettype wire

/* rtl/kli_datapath.sv */
// kli_datapath: key memories, clock, frac divider and channel blender
// depends on kli_pkg
`default_nettype none
module kli_datapath #(
  parameter int MAX_FRAMES = 128,
  parameter int AW = 7
) (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire kli_pkg::kli_cmd_t   cmd,
  output kli_pkg::kli_sts_t        sts,
  input  wire [31:0]               start_x,
  input  wire [31:0]               start_z,
  input  wire [30:0]               dt,
  input  wire [31:0]               f_time,
  input  wire [9*32-1:0]           f_ch,     // x,z,y,yaw,pitch,ls,rs,lh,rh
  output logic [1:0]               o_status,
  output logic [9*32-1:0]          o_pose
);
  localparam int CW = AW + 1;
  localparam int NC = kli_pkg::NUM_CH;

  logic [31:0] tmem [MAX_FRAMES];
  logic [31:0] cmem [MAX_FRAMES*NC];
  logic [31:0] t_rd, c_rd;
  logic [CW-1:0] cnt_r;
  logic [CW-1:0] idx_r;
  logic [31:0] clk_r, t0_r;
  logic [AW-1:0] t_addr;
  logic [$clog2(MAX_FRAMES*NC)-1:0] c_waddr, c_raddr;
  logic [3:0] wch_r, rch_r, ach_r;
  logic       c_ph_r;            // 0 prev, 1 next
  logic       app_r;
  logic [NC*32-1:0] app_d_r;
  logic [CW-1:0] app_row_r;
  logic [32:0] num_r, den_r, rem_r;
  logic [16:0] q_r;
  logic [5:0]  dcnt_r;
  logic [16:0] frac;
  logic signed [31:0] prev_r;
  logic signed [49:0] pa_r, pb_r;
  logic [9*32-1:0] pose_r;

  assign sts.full = (cnt_r == CW'(MAX_FRAMES));
  assign sts.few = (cnt_r < CW'(2));
  assign sts.scan_end = (idx_r >= cnt_r);
  assign sts.scan_hit = ($signed(clk_r) < $signed(t_rd));
  assign sts.div_done = (dcnt_r == 6'd0);
  assign sts.ch_last = (ach_r == 4'(NC-1));

  // time memory address
  always_comb begin
    if (cmd.start_ld) t_addr = '0;
    else if (cmd.seg_rd) t_addr = idx_r[AW-1:0] - AW'(1);
    else t_addr = idx_r[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.append) tmem[cnt_r[AW-1:0]] <= f_time;
    t_rd <= tmem[t_addr];
  end

  // channel writes: after append, the channels are written one per cycle
  assign c_waddr = $bits(c_waddr)'(app_row_r * NC + wch_r);
  assign c_raddr = $bits(c_raddr)'((c_ph_r ? idx_r : idx_r - CW'(1)) * NC + rch_r);
  always_ff @(posedge clk) begin
    if (app_r) cmem[c_waddr] <= app_d_r[wch_r*32 +: 32];
    c_rd <= cmem[c_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      app_r <= 1'b0;
      wch_r <= '0;
    end else if (cmd.append) begin
      app_r <= 1'b1;
      wch_r <= '0;
      app_row_r <= cnt_r;
      // x offset and z mirrored, both saturating; other channels as given
      app_d_r <= {f_ch[NC*32-1:64],
                  kli_pkg::sat_add($signed({start_z[31], start_z})
                                   - $signed({f_ch[63], f_ch[63:32]})),
                  kli_pkg::sat_add($signed({f_ch[31], f_ch[31:0]})
                                   + $signed({start_x[31], start_x}))};
    end else if (app_r) begin
      wch_r <= wch_r + 4'd1;
      if (wch_r == 4'(NC-1)) app_r <= 1'b0;
    end
  end

  // clock, count, scan, divider
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      clk_r <= '0;
      idx_r <= '0;
      dcnt_r <= '0;
    end else begin
      if (cmd.clear) begin
        cnt_r <= '0;
        clk_r <= '0;
      end
      if (cmd.append) cnt_r <= cnt_r + CW'(1);
      if (cmd.start_wr) clk_r <= t_rd;
      if (cmd.tick_add) begin
        clk_r <= kli_pkg::sat_add($signed({clk_r[31], clk_r}) + $signed({2'b00, dt}));
        idx_r <= CW'(1);
      end
      if (cmd.scan_step && !sts.scan_hit) idx_r <= idx_r + CW'(1);
      if (cmd.seg_ld) begin
        // t_rd holds t[idx-1], t0_r holds t[idx]
        num_r <= $signed({clk_r[31], clk_r}) - $signed({t0_r[31], t0_r});
        den_r <= $signed({t_rd[31], t_rd}) - $signed({t0_r[31], t0_r});
        dcnt_r <= 6'd49;
      end else if (cmd.div_step && dcnt_r != 6'd0) begin
        dcnt_r <= dcnt_r - 6'd1;
      end
      if (cmd.scan_step) t0_r <= t_rd;
    end
  end

  // restoring divide of |num|<<16 by |den|, 49 bits msb first
  logic [32:0] an, ad;
  logic [48:0] dvd;
  logic [33:0] trial;
  logic [32:0] rsh;
  assign an = num_r[32] ? 33'(-num_r) : num_r;
  assign ad = den_r[32] ? 33'(-den_r) : den_r;
  assign dvd = {an[32:0], 16'h0};
  assign rsh = {rem_r[31:0], dvd[6'(dcnt_r - 6'd1)]};
  assign trial = {1'b0, rsh} - {1'b0, ad};

  logic q_sat_r;
  always_ff @(posedge clk) begin
    if (cmd.seg_ld) begin
      q_sat_r <= 1'b0;
      rem_r <= '0;
      q_r <= '0;
    end else if (cmd.div_step && dcnt_r != 6'd0) begin
      if (!trial[33]) begin
        rem_r <= trial[32:0];
        if (dcnt_r > 6'd17) q_sat_r <= 1'b1;
        else q_r <= {q_r[15:0], 1'b1};
      end else begin
        rem_r <= rsh;
        if (dcnt_r <= 6'd17) q_r <= {q_r[15:0], 1'b0};
      end
    end
  end

  always_comb begin
    if (den_r == '0) frac = 17'h10000;
    else if (num_r != '0 && (num_r[32] != den_r[32])) frac = '0;
    else if (q_sat_r || q_r > 17'h10000) frac = 17'h10000;
    else frac = q_r;
  end

  // channel pass: read prev, read next, multiply, sum
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rch_r <= '0;
      c_ph_r <= 1'b0;
      ach_r <= '0;
    end else begin
      if (cmd.seg_ld) begin
        rch_r <= '0;
        c_ph_r <= 1'b0;
        ach_r <= '0;
      end
      if (cmd.ch_rd) c_ph_r <= ~c_ph_r;
      if (cmd.ch_mul && c_ph_r) prev_r <= c_rd;
      if (cmd.ch_mul && !c_ph_r) begin
        pa_r <= $signed({1'b0, frac}) * prev_r;
        pb_r <= $signed(18'h10000 - {1'b0, frac}) * $signed(c_rd);
        rch_r <= rch_r + 4'd1;
      end
      if (cmd.ch_acc) begin
        pose_r[ach_r*32 +: 32] <= 32'((pa_r + pb_r + 50'sd32768) >>> 16);
        ach_r <= ach_r + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      o_status <= cmd.st;
      o_pose <= (cmd.st == kli_pkg::ST_POSE) ? pose_r : '0;
    end
  end
endmodule
`default_nettype wire

/* rtl/kli_ctrl.sv */
// kli_ctrl: sequencer for commands, scan, divide and blend
// depends on kli_pkg
`default_nettype none
module kli_ctrl (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    in_fire,
  input  wire [1:0]              in_cmd,
  input  wire                    out_free,
  output logic                   busy,
  output logic                   out_set,
  output kli_pkg::kli_cmd_t      cmd,
  input  wire kli_pkg::kli_sts_t sts
);
  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_APP   = 11'b00000000010,
    S_ST1   = 11'b00000000100,
    S_ST2   = 11'b00000001000,
    S_SCRD  = 11'b00000010000,
    S_SCCMP = 11'b00000100000,
    S_SEGRD = 11'b00001000000,
    S_SEGLD = 11'b00010000000,
    S_DIV   = 11'b00100000000,
    S_CH    = 11'b01000000000,
    S_OUT   = 11'b10000000000
  } state_t;

  state_t state_r, state_nxt;
  kli_pkg::status_t st_r, st_nxt;
  logic [2:0] ph_r, ph_nxt;

  assign busy = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    st_nxt = st_r;
    ph_nxt = ph_r;
    cmd = '0;
    cmd.st = st_r;
    out_set = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          st_nxt = kli_pkg::ST_DONE;
          state_nxt = S_OUT;
          case (kli_pkg::cmd_t'(in_cmd))
            kli_pkg::CMD_CLEAR: cmd.clear = 1'b1;
            kli_pkg::CMD_APPEND: begin
              if (sts.full) st_nxt = kli_pkg::ST_FULL;
              else begin
                cmd.append = 1'b1;
                state_nxt = S_APP;
                ph_nxt = '0;
              end
            end
            kli_pkg::CMD_START: begin
              cmd.start_ld = 1'b1;
              state_nxt = S_ST2;
            end
            default: begin
              cmd.tick_add = 1'b1;
              state_nxt = S_SCRD;
            end
          endcase
        end
      end
      S_APP: begin
        // wait out the channel writes
        ph_nxt = ph_r + 3'd1;
        if (ph_r == 3'd7) begin
          state_nxt = S_ST1;
        end
      end
      S_ST1: state_nxt = S_OUT;
      S_ST2: begin
        cmd.start_wr = 1'b1;
        state_nxt = S_OUT;
      end
      S_SCRD: begin
        if (sts.few || sts.scan_end) begin
          st_nxt = kli_pkg::ST_FIN;
          state_nxt = S_OUT;
        end else begin
          cmd.scan_rd = 1'b1;
          state_nxt = S_SCCMP;
        end
      end
      S_SCCMP: begin
        cmd.scan_step = 1'b1;
        state_nxt = sts.scan_hit ? S_SEGRD : S_SCRD;
      end
      S_SEGRD: begin
        cmd.seg_rd = 1'b1;
        state_nxt = S_SEGLD;
      end
      S_SEGLD: begin
        cmd.seg_ld = 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) begin
          state_nxt = S_CH;
          ph_nxt = '0;
        end
      end
      S_CH: begin
        // ph 0 read prev, 1 latch prev/read next, 2 multiply, 3 sum
        ph_nxt = ph_r + 3'd1;
        case (ph_r)
          3'd0: cmd.ch_rd = 1'b1;
          3'd1: begin cmd.ch_rd = 1'b1; cmd.ch_mul = 1'b1; end
          3'd2: cmd.ch_mul = 1'b1;
          default: begin
            cmd.ch_acc = 1'b1;
            ph_nxt = '0;
            if (sts.ch_last) begin
              st_nxt = kli_pkg::ST_POSE;
              state_nxt = S_OUT;
            end
          end
        endcase
      end
      S_OUT: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          out_set = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      st_r <= kli_pkg::ST_DONE;
      ph_r <= '0;
    end else begin
      state_r <= state_nxt;
      st_r <= st_nxt;
      ph_r <= ph_nxt;
    end
  end
endmodule
`default_nettype wire
